// ===== rtl/sha1_pkg.sv =====
// SHA-1 engine package: beat types, sequencer states, round constants and IV.
// No dependencies; imported by every module of the engine.
package sha1_pkg;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    // Working variables of the compression function
    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
    } work_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam int    NUM_WORDS   = 5;
    localparam int    NUM_ROUNDS  = 80;
    localparam int    BLOCK_BYTES = 64;
    localparam int    LEN_POS     = 56;

    localparam word_t K_0 = 32'h5A827999;
    localparam word_t K_1 = 32'h6ED9EBA1;
    localparam word_t K_2 = 32'h8F1BBCDC;
    localparam word_t K_3 = 32'hCA62C1D6;

    localparam word_t SHA1_IV [NUM_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [2:0] LAST_INDEX = 3'(NUM_WORDS - 1);

endpackage

// ===== rtl/sha1_rnd.sv =====
// SHA-1 round unit: one of the 80 compression rounds, shared over all of them.
// Depends on sha1_pkg.
module sha1_rnd (
    input  sha1_pkg::work_t cur,
    input  sha1_pkg::word_t wt,
    input  logic [6:0]      rnd,
    output sha1_pkg::work_t nxt
);
    import sha1_pkg::*;

    word_t f;
    word_t k;

    always_comb
    begin
        if (rnd < 7'd20)
        begin
            f = (cur.b & cur.c) | (~cur.b & cur.d);
            k = K_0;
        end
        else if (rnd < 7'd40)
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_1;
        end
        else if (rnd < 7'd60)
        begin
            f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
            k = K_2;
        end
        else
        begin
            f = cur.b ^ cur.c ^ cur.d;
            k = K_3;
        end
    end

    always_comb
    begin
        nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + wt;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

// ===== rtl/sha1_hash_engine_core.sv =====
// SHA-1 hash engine, top level: byte intake, padding sequencer, message
// schedule shift line and chaining value. Depends on sha1_pkg and sha1_rnd.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): one beat per message byte.
//   byte_present=0 with last_byte=1 ends a message without adding a byte.
//   A beat with neither flag set is swallowed.
//   Output channel (out_valid/out_ready/out_data): after a last beat the
//   five digest words H0..H4 come out as five beats, last_word on H4.
// Sequence:
//   A byte that does not complete a block only shifts into the buffer. A full
//   block is loaded into the working variables, run through 80 rounds on the
//   single shared round unit, then folded into the chaining value.
//   Padding shifts one byte per cycle up to the block end, for the final
//   block (or two), before the digest shows. No new byte is taken while a
//   block is padded or compressed.
// Reset/stall:
//   rst_n clears the chaining value to the SHA-1 IV and empties the buffer.
//   in_ready is low outside the idle state. While the digest is shown the
//   block waits on out_ready for as long as it takes; each word holds until
//   taken. After the fifth beat the engine re-initializes for a new message.
module sha1_hash_engine_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sha1_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sha1_pkg::out_beat_t  out_data
);
    import sha1_pkg::*;

    state_t      state_reg, state_next;
    logic [511:0] blk_reg, blk_next;        // block buffer / W shift line
    word_t       h_reg [NUM_WORDS];
    word_t       h_next [NUM_WORDS];
    work_t       work_reg, work_next;
    logic [6:0]  fill_reg, fill_next;       // bytes in the current block
    logic [63:0] bits_reg, bits_next;       // message length in bits
    logic [6:0]  rnd_reg, rnd_next;
    logic        pad_reg, pad_next;         // message ended, padding under way
    logic        mark_reg, mark_next;       // 0x80 already placed
    logic        final_reg, final_next;     // current block carries the length
    logic [2:0]  idx_reg, idx_next;

    work_t       rnd_out;
    word_t       w_new;
    logic [7:0]  pad_byte;

    // W[t+16] = rotl1(W[t+13] ^ W[t+8] ^ W[t+2] ^ W[t]); W[t] sits in the top word
    always_comb
    begin
        w_new = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ blk_reg[511:480];
        w_new = {w_new[30:0], w_new[31]};
    end

    sha1_rnd u_rnd (
        .cur (work_reg),
        .wt  (blk_reg[511:480]),
        .rnd (rnd_reg),
        .nxt (rnd_out)
    );

    // Padding byte: marker, then zeros, then length MSB first in the final block
    always_comb
    begin
        if (!mark_reg)
            pad_byte = PAD_MARK;
        else if (final_reg && fill_reg >= 7'(LEN_POS))
            pad_byte = bits_reg[63:56];
        else
            pad_byte = '0;
    end

    always_comb
    begin
        state_next = state_reg;
        blk_next   = blk_reg;
        work_next  = work_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        rnd_next   = rnd_reg;
        pad_next   = pad_reg;
        mark_next  = mark_reg;
        final_next = final_reg;
        idx_next   = idx_reg;
        for (int i = 0; i < NUM_WORDS; i++)
            h_next[i] = h_reg[i];
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.byte_present)
                    begin
                        blk_next  = {blk_reg[503:0], in_data.data_byte};
                        fill_next = fill_reg + 7'd1;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (in_data.last_byte)
                        pad_next = 1'b1;
                    if (in_data.byte_present && fill_reg == 7'(BLOCK_BYTES - 1))
                        state_next = ST_LOAD;
                    else if (in_data.last_byte)
                        state_next = ST_PAD;
                end
            end

            ST_PAD:
            begin
                blk_next  = {blk_reg[503:0], pad_byte};
                fill_next = fill_reg + 7'd1;
                if (!mark_reg)
                begin
                    mark_next = 1'b1;
                    // marker leaves room for the length in this block
                    if (fill_reg < 7'(LEN_POS))
                        final_next = 1'b1;
                end
                else if (final_reg && fill_reg >= 7'(LEN_POS))
                    bits_next = {bits_reg[55:0], 8'h00};
                if (fill_reg == 7'(BLOCK_BYTES - 1))
                    state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                work_next  = '{a: h_reg[0], b: h_reg[1], c: h_reg[2],
                               d: h_reg[3], e: h_reg[4]};
                rnd_next   = '0;
                state_next = ST_ROUND;
            end

            ST_ROUND:
            begin
                work_next = rnd_out;
                blk_next  = {blk_reg[479:0], w_new};
                rnd_next  = rnd_reg + 7'd1;
                if (rnd_reg == 7'(NUM_ROUNDS - 1))
                    state_next = ST_ADD;
            end

            ST_ADD:
            begin
                h_next[0] = h_reg[0] + work_reg.a;
                h_next[1] = h_reg[1] + work_reg.b;
                h_next[2] = h_reg[2] + work_reg.c;
                h_next[3] = h_reg[3] + work_reg.d;
                h_next[4] = h_reg[4] + work_reg.e;
                fill_next = '0;
                if (!pad_reg)
                    state_next = ST_IDLE;
                else if (final_reg)
                begin
                    idx_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    // length spills into an extra block
                    final_next = 1'b1;
                    state_next = ST_PAD;
                end
            end

            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (idx_reg == LAST_INDEX)
                    begin
                        for (int i = 0; i < NUM_WORDS; i++)
                            h_next[i] = SHA1_IV[i];
                        fill_next  = '0;
                        bits_next  = '0;
                        pad_next   = 1'b0;
                        mark_next  = 1'b0;
                        final_next = 1'b0;
                        idx_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                        idx_next = idx_reg + 3'd1;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            rnd_reg   <= '0;
            pad_reg   <= 1'b0;
            mark_reg  <= 1'b0;
            final_reg <= 1'b0;
            idx_reg   <= '0;
            for (int i = 0; i < NUM_WORDS; i++)
                h_reg[i] <= SHA1_IV[i];
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            rnd_reg   <= rnd_next;
            pad_reg   <= pad_next;
            mark_reg  <= mark_next;
            final_reg <= final_next;
            idx_reg   <= idx_next;
            for (int i = 0; i < NUM_WORDS; i++)
                h_reg[i] <= h_next[i];
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        work_reg <= work_next;
    end

    assign out_data.digest_word = h_reg[idx_reg];
    assign out_data.word_index  = idx_reg;
    assign out_data.last_word   = (idx_reg == LAST_INDEX);

endmodule

// ===== rtl/sha1_chk.sv =====
// Port-level checker for the SHA-1 engine, bound to the top level.
// Depends on sha1_pkg and sha1_hash_engine_core.
module sha1_chk (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  sha1_pkg::out_beat_t  out_data
);
    import sha1_pkg::*;

    // no intake while the digest is being delivered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(out_valid && in_ready))
        else $error("input accepted while digest pending");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_word == (out_data.word_index == LAST_INDEX)))
        else $error("last_word does not match word_index");

    // words come out back to back in order
    a_next_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_data.last_word) |=>
        (out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1))
        else $error("digest word sequence broken");

    a_end_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_data.last_word) |=> (!out_valid && in_ready))
        else $error("engine not back to idle after digest");

    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (out_data.word_index == 3'd0))
        else $error("digest does not start at word 0");

endmodule

bind sha1_hash_engine_core sha1_chk u_sha1_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for sha1_hash_engine_core: directed table, then random messages.
// Carries its own SHA-1 model to predict each digest beat. Needs rtl/sha1_pkg.sv only
// for the beat types; the round constants and IV are restated here.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1_pkg::*;

    localparam int unsigned RAND_ITEMS  = 480;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned DRAIN_WAIT  = 400;
    localparam int unsigned MAX_GAP     = 40;

    // FIPS 180 constants, kept independent of the package
    localparam logic [31:0] RK_00_19 = 32'h5A827999;
    localparam logic [31:0] RK_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] RK_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] RK_60_79 = 32'hCA62C1D6;
    localparam logic [31:0] INIT_H [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Well-known digests, typed in as H0..H4 concatenated
    localparam logic [159:0] DIG_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] DIG_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

    // Message lengths around the padding and block boundaries
    localparam int unsigned EDGE_LEN [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    // Directed stimulus row; typed=1 means the digest is given, not predicted
    typedef struct packed {
        logic [7:0]   data;
        logic         present;
        logic         last;
        logic         typed;
        logic [159:0] dig;
    } dir_row_t;

    localparam int unsigned N_DIR = 17;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, DIG_EMPTY},  // empty message straight after reset
        '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},     // no byte, no last: swallowed
        '{8'hFF, 1'b0, 1'b0, 1'b0, 160'h0},     // same, data bits set but ignored
        '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},     // "a"
        '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},     // "b"
        '{8'h63, 1'b1, 1'b1, 1'b1, DIG_ABC},    // "c" with last: byte then finish
        '{8'h00, 1'b0, 1'b1, 1'b1, DIG_EMPTY},  // empty again: engine re-initialized
        '{8'h00, 1'b1, 1'b1, 1'b0, 160'h0},     // single zero byte
        '{8'hFF, 1'b1, 1'b1, 1'b0, 160'h0},     // single all-ones byte
        '{8'h55, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h00, 1'b0, 1'b0, 1'b0, 160'h0},     // no-op inside a message
        '{8'hAA, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hFF, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'hAA, 1'b0, 1'b1, 1'b0, 160'h0},     // empty final beat ends 4-byte message
        '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
        '{8'h7F, 1'b1, 1'b1, 1'b0, 160'h0}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_beat_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_beat_t out_data;

    sha1_hash_engine_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Predictor state: chaining value, block bytes, fill level, bit length
    logic [31:0] hash_h [5];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [63:0] msg_len_bits;

    out_beat_t   digest_q [$];    // digest beats still owed by the engine
    int unsigned err_cnt;
    int unsigned items_sent;
    int unsigned cycle_cnt;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    function automatic logic [31:0] rol32(logic [31:0] x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        hash_h       = INIT_H;
        blk_fill     = 0;
        msg_len_bits = '0;
    endfunction

    // One 80-round compression of blk_bytes into hash_h
    function automatic void sha1_compress();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, t_sum;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int t = 0; t < 80; t++)
        begin
            if (t < 16)
                wt = w[t];
            else
            begin
                // rolling 16-word schedule window
                wt = rol32(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^ w[(t + 2) % 16] ^ w[t % 16], 1);
                w[t % 16] = wt;
            end
            if (t < 20)
            begin
                f = (b & c) | (~b & d);
                k = RK_00_19;
            end
            else if (t < 40)
            begin
                f = b ^ c ^ d;
                k = RK_20_39;
            end
            else if (t < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RK_40_59;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RK_60_79;
            end
            t_sum = rol32(a, 5) + f + e + k + wt;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t_sum;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    function automatic void push_msg_byte(logic [7:0] v);
        blk_bytes[blk_fill] = v;
        blk_fill++;
        if (blk_fill == 64)
        begin
            sha1_compress();
            blk_fill = 0;
        end
    endfunction

    // Advance the model by one accepted input beat; queue the digest on a last beat.
    // With typed set, the queued words come from dig instead of the model.
    function automatic void predict_digest(in_beat_t bt, logic typed, logic [159:0] dig);
        out_beat_t   r;
        logic [63:0] total;
        if (bt.byte_present)
        begin
            msg_len_bits += 64'd8;
            push_msg_byte(bt.data_byte);
        end
        if (!bt.last_byte)
            return;
        total = msg_len_bits;
        // 0x80 marker, zero fill to byte 56 (may spill into an extra block), length
        push_msg_byte(PAD_BYTE);
        while (blk_fill != 56)
            push_msg_byte(8'h00);
        for (int i = 0; i < 8; i++)
            blk_bytes[56 + i] = total[63 - 8*i -: 8];
        sha1_compress();
        for (int i = 0; i < 5; i++)
        begin
            r.digest_word = typed ? dig[159 - 32*i -: 32] : hash_h[i];
            r.word_index  = 3'(i);
            r.last_word   = (i == 4);
            digest_q.push_back(r);
        end
        restart_hash();
    endfunction

    function automatic void check_digest_beat(out_beat_t got);
        out_beat_t want;
        if (digest_q.size() == 0)
        begin
            $error("unexpected digest beat: digest_word %h word_index %0d last_word %0b",
                   got.digest_word, got.word_index, got.last_word);
            err_cnt++;
            return;
        end
        want = digest_q.pop_front();
        if (got.digest_word !== want.digest_word)
        begin
            $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
            err_cnt++;
        end
        if (got.word_index !== want.word_index)
        begin
            $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
            err_cnt++;
        end
        if (got.last_word !== want.last_word)
        begin
            $error("last_word: expected %0b, got %0b", want.last_word, got.last_word);
            err_cnt++;
        end
    endfunction

    // Offer one beat after a random idle gap, hold it until taken, then predict.
    // With no gap, valid stays high and only the payload changes this edge.
    task automatic send_beat(in_beat_t bt, logic typed, logic [159:0] dig);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99, 0) < send_idle_pct && gap < MAX_GAP)
            gap++;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= bt;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_digest(bt, typed, dig);
    endtask

    // Drop valid right at the edge where the previous beat was taken
    task automatic hold_sender();
        in_valid <= 1'b0;
    endtask

    // One random message: mostly short, some at block edges, a few long.
    // Stray no-op beats are mixed in; the end is either a byte with last
    // or a separate empty final beat.
    task automatic send_message();
        int unsigned pick;
        int unsigned len;
        logic        tail_last;
        in_beat_t    bt;
        pick = $urandom_range(99, 0);
        if (pick < 70)
            len = $urandom_range(20, 0);
        else if (pick < 88)
            len = EDGE_LEN[$urandom_range(7, 0)];
        else
            len = $urandom_range(130, 21);
        tail_last = (len != 0) && ($urandom_range(1, 0) == 1);
        for (int unsigned i = 0; i < len; i++)
        begin
            if ($urandom_range(9, 0) == 0)
            begin
                bt.data_byte    = 8'($urandom);
                bt.byte_present = 1'b0;
                bt.last_byte    = 1'b0;
                send_beat(bt, 1'b0, '0);
                items_sent++;
            end
            bt.data_byte    = 8'($urandom);
            bt.byte_present = 1'b1;
            bt.last_byte    = tail_last && (i == len - 1);
            send_beat(bt, 1'b0, '0);
            items_sent++;
        end
        if (!tail_last)
        begin
            bt.data_byte    = 8'($urandom);
            bt.byte_present = 1'b0;
            bt.last_byte    = 1'b1;
            send_beat(bt, 1'b0, '0);
            items_sent++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Output side: check each taken digest beat, then pick next cycle's ready
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                check_digest_beat(out_data);
            out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    initial
    begin
        in_beat_t    bt;
        int unsigned phase;
        int unsigned next_phase;

        err_cnt        = 0;
        items_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        phase          = 0;
        restart_hash();
        in_valid <= 1'b0;
        in_data  <= '0;
        rst_n    <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back
        for (int i = 0; i < N_DIR; i++)
        begin
            bt.data_byte    = DIR_ROWS[i].data;
            bt.byte_present = DIR_ROWS[i].present;
            bt.last_byte    = DIR_ROWS[i].last;
            send_beat(bt, DIR_ROWS[i].typed, DIR_ROWS[i].dig);
        end

        // Random messages in four idling phases:
        //   0 no idling, 1 sender idle 75%, 2 receiver stalls 75%, 3 both 24%.
        // At each phase change the sender holds off until every digest is out.
        // Phases advance one at a time so a long message never skips one.
        while (items_sent < RAND_ITEMS)
        begin
            next_phase = (items_sent * 4) / RAND_ITEMS;
            if (next_phase > phase)
            begin
                phase = phase + 1;
                hold_sender();
                while (digest_q.size() != 0)
                    @(posedge clk);
                case (phase)
                    1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                    default: begin send_idle_pct = 24; recv_stall_pct = 24; end
                endcase
            end
            send_message();
        end

        hold_sender();
        while (digest_q.size() != 0)
            @(posedge clk);
        // let any stray extra beats show up before the verdict
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0 && digest_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sha1_pkg.sv
rtl/sha1_rnd.sv
rtl/sha1_hash_engine_core.sv
rtl/sha1_chk.sv
tb/tb_top.sv
